@@ rtl/core/gdo_pkg.sv @@
// Shared widths, constants and calendar helpers for the date offset block.
package gdo_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 17;

    // Walk year must hold a start year of up to 14 bits plus a few centuries,
    // and any year limit up to 65535 plus the same margin.
    localparam int WALK_YEAR_W = 17;
    localparam int MOD400_W    = 9;

    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY    = 100;

    localparam logic [WALK_YEAR_W-1:0] DEFAULT_YEAR  = WALK_YEAR_W'(1900);
    localparam logic [MOD400_W-1:0]    DEFAULT_MOD   = MOD400_W'(1900 % LEAP_CYCLE);
    localparam logic [MONTH_W-1:0]     MONTH_JAN     = MONTH_W'(1);
    localparam logic [MONTH_W-1:0]     MONTH_DEC     = MONTH_W'(12);
    localparam logic [DAY_W-1:0]       DAY_LAST_DEC  = DAY_W'(31);

    // Leap rule from the low year bits and the year modulo 400.
    function automatic logic is_leap(input logic [1:0] year_lo,
                                     input logic [MOD400_W-1:0] mod400);
        logic century;
        century = (mod400 == MOD400_W'(0)) || (mod400 == MOD400_W'(CENTURY))
               || (mod400 == MOD400_W'(2 * CENTURY)) || (mod400 == MOD400_W'(3 * CENTURY));
        return ((year_lo == 2'd0) && !century) || (mod400 == MOD400_W'(0));
    endfunction

    // Month length; zero for codes that name no month.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    len = DAY_W'(0);
        endcase
        return len;
    endfunction

endpackage

@@ rtl/core/gdo_req_if.sv @@
// Request channel: start date and signed day offset.
interface gdo_req_if
    import gdo_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [YEAR_W-1:0]          start_year;
    logic [MONTH_W-1:0]         start_month;
    logic [DAY_W-1:0]           start_day;
    logic signed [OFFSET_W-1:0] day_offset;

    modport source (output valid, start_year, start_month, start_day, day_offset,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_offset,
                    output ready);
endinterface

@@ rtl/core/gdo_rsp_if.sv @@
// Response channel: shifted date and status flags.
interface gdo_rsp_if
    import gdo_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               start_invalid;
    logic               range_error;

    modport source (output valid, result_year, result_month, result_day, start_invalid,
                    range_error, input ready);
    modport sink   (input valid, result_year, result_month, result_day, start_invalid,
                    range_error, output ready);
endinterface

@@ rtl/core/gregorian_date_day_offset.sv @@
// Gregorian date shifter: walks a signed day offset month by month.
//
//   channel   | role   | carries
//   ----------+--------+--------------------------------------------------
//   date_req  | sink   | start_year, start_month, start_day, day_offset
//   date_rsp  | source | result_year, result_month, result_day, flags
//
// Each item is accepted, then its year is reduced modulo 400 by repeated
// subtraction, then the offset is walked one month per step, then the result is passed on.
// The month walk through the shared add/compare unit dominates the run time.
// date_req.ready is high only while no item is in work.
// The result register holds a finished date while date_rsp stalls.
// Reset (rst_n, async, active low) clears the sequencer and result valid.
module gregorian_date_day_offset
    import gdo_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic     clk,
    input  logic     rst_n,
    gdo_req_if.sink   date_req,
    gdo_rsp_if.source date_rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [WALK_YEAR_W-1:0] YEAR_LIMIT = WALK_YEAR_W'(MAX_YEAR);
    localparam logic [MOD400_W-1:0]    MOD_LAST   = MOD400_W'(LEAP_CYCLE - 1);

    logic [1:0]               state_reg, state_next;
    logic [WALK_YEAR_W-1:0]   year_reg, year_next;
    logic [YEAR_W-1:0]        work_reg, work_next;
    logic [MOD400_W-1:0]      mod_reg, mod_next;
    logic [MONTH_W-1:0]       month_reg, month_next;
    logic [DAY_W-1:0]         d0_reg, d0_next;
    logic [OFFSET_W-1:0]      rem_reg, rem_next;
    logic                     back_reg, back_next;
    logic                     bad_reg, bad_next;
    logic                     rng_reg, rng_next;
    logic [YEAR_W-1:0]        res_year_reg, res_year_next;
    logic [MONTH_W-1:0]       res_month_reg, res_month_next;
    logic [DAY_W-1:0]         res_day_reg, res_day_next;

    logic                     out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]        out_year_reg;
    logic [MONTH_W-1:0]       out_month_reg;
    logic [DAY_W-1:0]         out_day_reg;
    logic                     out_bad_reg, out_rng_reg;

    logic [OFFSET_W-1:0]      off_bits;
    logic                     start_leap;
    logic [DAY_W-1:0]         start_len;
    logic                     start_bad;
    logic                     cur_leap;
    logic [DAY_W-1:0]         cur_len;
    logic [OFFSET_W:0]        fwd_sum;
    logic                     fwd_fits, back_fits;
    logic [WALK_YEAR_W-1:0]   prev_year;
    logic [MOD400_W-1:0]      prev_mod;
    logic [MONTH_W-1:0]       prev_month;
    logic [DAY_W-1:0]         prev_len;
    logic                     load_out;

    assign off_bits  = date_req.day_offset;
    assign date_req.ready = (state_reg == ST_IDLE);

    // Start date check, valid once work_reg holds the year modulo 400.
    assign start_leap = is_leap(year_reg[1:0], work_reg[MOD400_W-1:0]);
    assign start_len  = month_days(month_reg, start_leap);
    assign start_bad  = (year_reg == '0) || (start_len == '0) || (d0_reg == '0)
                     || (d0_reg > start_len);

    // Shared walk unit.
    assign cur_leap  = is_leap(year_reg[1:0], mod_reg);
    assign cur_len   = month_days(month_reg, cur_leap);
    assign fwd_sum   = {1'b0, rem_reg} + (OFFSET_W + 1)'(d0_reg);
    assign fwd_fits  = fwd_sum < (OFFSET_W + 1)'(cur_len);
    assign back_fits = rem_reg <= OFFSET_W'(d0_reg);

    always_comb
    begin
        if (month_reg == MONTH_JAN)
        begin
            prev_month = MONTH_DEC;
            prev_year  = year_reg - WALK_YEAR_W'(1);
            prev_mod   = (mod_reg == '0) ? MOD_LAST : mod_reg - MOD400_W'(1);
        end
        else
        begin
            prev_month = month_reg - MONTH_W'(1);
            prev_year  = year_reg;
            prev_mod   = mod_reg;
        end
        prev_len = month_days(prev_month, is_leap(prev_year[1:0], prev_mod));
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || date_rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        year_next      = year_reg;
        work_next      = work_reg;
        mod_next       = mod_reg;
        month_next     = month_reg;
        d0_next        = d0_reg;
        rem_next       = rem_reg;
        back_next      = back_reg;
        bad_next       = bad_reg;
        rng_next       = rng_reg;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (date_req.valid)
                begin
                    year_next  = WALK_YEAR_W'(date_req.start_year);
                    work_next  = date_req.start_year;
                    month_next = date_req.start_month;
                    d0_next    = date_req.start_day;
                    back_next  = off_bits[OFFSET_W-1];
                    rem_next   = off_bits[OFFSET_W-1] ? (~off_bits + OFFSET_W'(1)) : off_bits;
                    bad_next   = 1'b0;
                    rng_next   = 1'b0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (work_reg >= YEAR_W'(LEAP_CYCLE))
                begin
                    work_next = work_reg - YEAR_W'(LEAP_CYCLE);
                end
                else if (start_bad)
                begin
                    // Replace with the default date and keep the offset.
                    year_next  = DEFAULT_YEAR;
                    mod_next   = DEFAULT_MOD;
                    month_next = MONTH_JAN;
                    d0_next    = '0;
                    bad_next   = 1'b1;
                    state_next = ST_WALK;
                end
                else
                begin
                    mod_next   = work_reg[MOD400_W-1:0];
                    d0_next    = d0_reg - DAY_W'(1);
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (year_reg == '0)
                begin
                    res_year_next  = YEAR_W'(1);
                    res_month_next = MONTH_JAN;
                    res_day_next   = DAY_W'(1);
                    rng_next       = 1'b1;
                    state_next     = ST_DONE;
                end
                else if ((!back_reg && fwd_fits) || (back_reg && back_fits)
                         || (!back_reg && year_reg > YEAR_LIMIT))
                begin
                    if (year_reg > YEAR_LIMIT)
                    begin
                        res_year_next  = YEAR_W'(MAX_YEAR);
                        res_month_next = MONTH_DEC;
                        res_day_next   = DAY_LAST_DEC;
                        rng_next       = 1'b1;
                    end
                    else
                    begin
                        res_year_next  = year_reg[YEAR_W-1:0];
                        res_month_next = month_reg;
                        res_day_next   = back_reg
                                       ? d0_reg - rem_reg[DAY_W-1:0] + DAY_W'(1)
                                       : fwd_sum[DAY_W-1:0] + DAY_W'(1);
                    end
                    state_next = ST_DONE;
                end
                else if (!back_reg)
                begin
                    // Advance to the first day of the next month.
                    rem_next = rem_reg - OFFSET_W'(cur_len - d0_reg);
                    d0_next  = '0;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + WALK_YEAR_W'(1);
                        mod_next   = (mod_reg == MOD_LAST) ? '0 : mod_reg + MOD400_W'(1);
                    end
                    else
                    begin
                        month_next = month_reg + MONTH_W'(1);
                    end
                end
                else
                begin
                    // Step back to the last day of the previous month.
                    rem_next   = rem_reg - OFFSET_W'(d0_reg) - OFFSET_W'(1);
                    month_next = prev_month;
                    year_next  = prev_year;
                    mod_next   = prev_mod;
                    d0_next    = prev_len - DAY_W'(1);
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !date_rsp.ready) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        work_reg      <= work_next;
        mod_reg       <= mod_next;
        month_reg     <= month_next;
        d0_reg        <= d0_next;
        rem_reg       <= rem_next;
        back_reg      <= back_next;
        bad_reg       <= bad_next;
        rng_reg       <= rng_next;
        res_year_reg  <= res_year_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
        if (load_out)
        begin
            out_year_reg  <= res_year_reg;
            out_month_reg <= res_month_reg;
            out_day_reg   <= res_day_reg;
            out_bad_reg   <= bad_reg;
            out_rng_reg   <= rng_reg;
        end
    end

    assign date_rsp.valid         = out_valid_reg;
    assign date_rsp.result_year   = out_year_reg;
    assign date_rsp.result_month  = out_month_reg;
    assign date_rsp.result_day    = out_day_reg;
    assign date_rsp.start_invalid = out_bad_reg;
    assign date_rsp.range_error   = out_rng_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        date_req.valid && date_req.ready |=> state_reg == ST_MOD)
        else $error("accepted transfer did not start the year reduction");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> mod_reg < MOD400_W'(LEAP_CYCLE))
        else $error("year modulo 400 out of range during walk");

    a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK && year_reg != '0 |-> d0_reg < cur_len)
        else $error("day index outside current month during walk");

    a_rsp_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        date_rsp.valid |-> date_rsp.result_month >= MONTH_JAN
            && date_rsp.result_month <= MONTH_DEC && date_rsp.result_day != '0)
        else $error("response carries an impossible month or day");

endmodule
